// ===== rtl/gcp_pkg.sv =====
// Package for the gamma conversion probability block.
// Fixed point widths, path codes and the coefficient tables; no dependencies.
package gcp_pkg;

  localparam int E_W    = 24;
  localparam int TH_W   = 15;
  localparam int LOG_W  = 29;
  localparam int X_W    = 21;
  localparam int ACC_W  = 48;
  localparam int F_W    = 30;
  localparam int S24_W  = 38;
  localparam int LOG_LAT = 25;
  localparam int NSTG   = 37;

  localparam logic [E_W-1:0] THRESH_KEV = E_W'(1022);
  localparam logic [E_W-1:0] EMAX_KEV   = E_W'(10000000);
  localparam logic signed [16:0] ANGLE_MAX = 17'sd23040;

  typedef enum logic [2:0] {
    PATH_ANGLE    = 3'd0,
    PATH_ALL      = 3'd1,
    PATH_FIXED    = 3'd2,
    PATH_COMPUTED = 3'd3,
    PATH_BELOW    = 3'd4
  } path_t;

  typedef enum logic [1:0] {
    REG_ATOMIC = 2'd0,
    REG_FIXED  = 2'd1,
    REG_SET    = 2'd2
  } reg_idx_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [F_W-1:0]   f_t;
  typedef logic signed [23:0]      k_t;

  localparam longint Q40 = 64'sd1099511627776;
  localparam longint Q36 = 64'sd68719476736;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint Q24 = 64'sd16777216;

  localparam logic [29:0] LN2_Q30 =
    30'((64'sd6931471806 * Q30 + 64'sd5000000000) / 64'sd10000000000);
  localparam logic [LOG_W-1:0] LOG2_ME_Q24 =
    LOG_W'((64'sd899717683 * Q24 + 64'sd50000000) / 64'sd100000000);

  localparam acc_t XS_COEF [3][6] = '{
    '{ acc_t'((64'sd87842 * Q40 + 64'sd50000000) / 64'sd100000000),
       acc_t'(-((64'sd19625 * Q40 + 64'sd5000000) / 64'sd10000000)),
       acc_t'((64'sd12949 * Q40 + 64'sd5000000) / 64'sd10000000),
       acc_t'(-((64'sd20028 * Q40 + 64'sd50000000) / 64'sd100000000)),
       acc_t'((64'sd12575 * Q40 + 64'sd500000000) / 64'sd1000000000),
       acc_t'(-((64'sd28333 * Q40 + 64'sd50000000000) / 64'sd100000000000)) },
    '{ acc_t'(-((64'sd10342 * Q40 + 64'sd500000000) / 64'sd1000000000)),
       acc_t'((64'sd17692 * Q40 + 64'sd500000000) / 64'sd1000000000),
       acc_t'(-((64'sd82391 * Q40 + 64'sd5000000000) / 64'sd10000000000)),
       acc_t'((64'sd13063 * Q40 + 64'sd5000000000) / 64'sd10000000000),
       acc_t'(-((64'sd90815 * Q40 + 64'sd500000000000) / 64'sd1000000000000)),
       acc_t'((64'sd23586 * Q40 + 64'sd5000000000000) / 64'sd10000000000000) },
    '{ acc_t'(-((64'sd45263 * Q40 + 64'sd50000000) / 64'sd100000000)),
       acc_t'((64'sd11161 * Q40 + 64'sd5000000) / 64'sd10000000),
       acc_t'(-((64'sd86749 * Q40 + 64'sd50000000) / 64'sd100000000)),
       acc_t'((64'sd21773 * Q40 + 64'sd50000000) / 64'sd100000000),
       acc_t'(-((64'sd20467 * Q40 + 64'sd500000000) / 64'sd1000000000)),
       acc_t'((64'sd65372 * Q40 + 64'sd50000000000) / 64'sd100000000000) }
  };

  localparam k_t ANG_SCALE [4] = '{
    k_t'((64'sd4319 * Q30 + 64'sd500000) / 64'sd1000000),
    k_t'((64'sd649 * Q30 + 64'sd50000) / 64'sd100000),
    k_t'((64'sd380904 * Q30 + 64'sd50000000) / 64'sd100000000),
    k_t'((64'sd4319 * Q30 + 64'sd500000) / 64'sd1000000)
  };

  localparam acc_t ANG_COEF [4][4] = '{
    '{ acc_t'(-((64'sd2322 * Q36 + 64'sd50000) / 64'sd100000)),
       acc_t'((64'sd359 * Q36 + 64'sd500000) / 64'sd1000000),
       acc_t'(0), acc_t'(0) },
    '{ acc_t'((64'sd740 * Q36 + 64'sd50000) / 64'sd100000),
       acc_t'((64'sd397 * Q36 + 64'sd5000000) / 64'sd10000000),
       acc_t'(0), acc_t'(0) },
    '{ acc_t'(-((64'sd777771 * Q36 + 64'sd5000000) / 64'sd10000000)),
       acc_t'((64'sd522763 * Q36 + 64'sd50000000) / 64'sd100000000),
       acc_t'(-((64'sd133942 * Q36 + 64'sd500000000) / 64'sd1000000000)),
       acc_t'((64'sd149021 * Q36 + 64'sd50000000000) / 64'sd100000000000) },
    '{ acc_t'(-((64'sd2322 * Q36 + 64'sd50000) / 64'sd100000)),
       acc_t'((64'sd359 * Q36 + 64'sd500000) / 64'sd1000000),
       acc_t'(0), acc_t'(0) }
  };

  localparam acc_t ANG_ONE = acc_t'(Q36);

  typedef struct packed {
    path_t            path;
    logic [E_W-1:0]   val;
    logic [TH_W-1:0]  th;
    f_t               f;
  } side_t;

endpackage

// ===== rtl/gcp_log2.sv =====
// Pipelined base-2 logarithm in Q.24 by repeated squaring, one squaring per stage.
// Depends on gcp_pkg; e is registered, and every squaring stage is registered on the way to log_q24.
module gcp_log2 (
  input  logic                         clk,
  input  logic [gcp_pkg::E_W-1:0]      e,
  output logic [gcp_pkg::LOG_W-1:0]    log_q24
);
  import gcp_pkg::*;

  logic [4:0]  pos;
  logic [54:0] sh;
  logic [30:0] y_r  [0:24];
  logic [4:0]  p_r  [0:24];
  logic [23:0] fr_r [0:24];

  always_comb begin
    pos = '0;
    for (int i = 0; i < E_W; i++) begin
      if (e[i]) pos = 5'(i);
    end
    sh = 55'(e) << (5'd30 - pos);
  end

  always_ff @(posedge clk) begin
    y_r[0]  <= sh[30:0];
    p_r[0]  <= pos;
    fr_r[0] <= '0;
  end

  for (genvar k = 0; k < 24; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    always_comb begin
      sq = 62'(y_r[k]) * 62'(y_r[k]);
      t  = sq[61:30];
    end
    always_ff @(posedge clk) begin
      p_r[k+1] <= p_r[k];
      if (t[31]) begin
        y_r[k+1]  <= t[31:1];
        fr_r[k+1] <= {fr_r[k][22:0], 1'b1};
      end else begin
        y_r[k+1]  <= t[30:0];
        fr_r[k+1] <= {fr_r[k][22:0], 1'b0};
      end
    end
  end

  assign log_q24 = {p_r[24], fr_r[24]};

endmodule

// ===== rtl/gamma_conversion_probability.sv =====
// Top level of the gamma conversion probability block.
// Depends on gcp_pkg and gcp_log2.
//
// One photon is taken every clock (busy stays low) and its result appears
// for a single cycle with out_valid; the result cannot be held off. The
// result passes through the 24-stage squaring logarithm followed by the
// Horner stages of the cross section polynomials and the final scaling
// multiplies. cfg_ready is always high; write registers only while idle.
module gamma_conversion_probability (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [23:0]                   in_photon_energy,
  input  logic signed [16:0]            in_polar_angle,
  output logic                          out_valid,
  output logic [23:0]                   out_probability,
  output logic [2:0]                    out_path_taken,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);
  import gcp_pkg::*;

  logic [6:0]  atomic_number_r;
  logic [16:0] fixed_probability_r;
  logic [1:0]  coefficient_set_r;

  logic        vld_r  [0:NSTG-1];
  side_t       side_r [0:NSTG-1];
  side_t       side_nxt;
  logic [E_W-1:0] e_r, e_nxt;

  acc_t        ang_r   [1:4];
  acc_t        ang_nxt [1:4];
  f_t          f_nxt;
  logic signed [63:0] ang_pr [1:4];
  logic signed [59:0] f_pr;
  logic signed [35:0] a_q24;

  logic [LOG_W-1:0] log_q24;
  logic [LOG_W-1:0] d;
  logic [58:0]      x_pr;
  logic [X_W-1:0]   x_r [0:4];

  acc_t             hacc_r   [3][5];
  acc_t             hacc_nxt [3][5];
  logic signed [69:0] h_pr   [3][5];

  logic signed [7:0]  zs;
  logic signed [8:0]  z1;
  logic signed [55:0] p0_r, p1_r, p0_nxt, p1_nxt, p0b_r;
  acc_t               c2_r, c2b_r;
  logic signed [63:0] q1_r, q1_nxt, t_r, t_nxt, s_r;
  logic signed [72:0] s_pr;
  logic signed [47:0] s_sh;
  logic signed [S24_W-1:0] s24_r, s24_nxt;
  logic signed [67:0] fin_pr;
  logic signed [35:0] fin;
  logic [23:0]        prob_c;

  logic        out_valid_r;
  logic [23:0] out_probability_r;
  path_t       out_path_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atomic_number_r     <= 7'd41;
      fixed_probability_r <= '0;
      coefficient_set_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ATOMIC: atomic_number_r     <= cfg_data[6:0];
        REG_FIXED:  fixed_probability_r <= cfg_data;
        REG_SET:    coefficient_set_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // entry: pick the path and clamp the energy
  always_comb begin
    side_nxt      = '0;
    side_nxt.th   = in_polar_angle[TH_W-1:0];
    e_nxt         = (in_photon_energy > EMAX_KEV) ? EMAX_KEV : in_photon_energy;
    if (in_polar_angle < 0 || in_polar_angle > ANGLE_MAX) begin
      side_nxt.path = PATH_ANGLE;
    end else if (fixed_probability_r[16]) begin
      side_nxt.path = PATH_ALL;
      side_nxt.val  = 24'h010000;
    end else if (fixed_probability_r != '0) begin
      side_nxt.path = PATH_FIXED;
      side_nxt.val  = 24'(fixed_probability_r);
    end else if (in_photon_energy < THRESH_KEV) begin
      side_nxt.path = PATH_BELOW;
    end else begin
      side_nxt.path = PATH_COMPUTED;
    end
  end

  // angular polynomial and scale
  always_comb begin
    ang_pr[1]  = ANG_COEF[coefficient_set_r][3] * $signed({1'b0, side_r[0].th});
    ang_nxt[1] = ANG_COEF[coefficient_set_r][2] + acc_t'(ang_pr[1] >>> 8);
    for (int k = 2; k <= 3; k++) begin
      ang_pr[k]  = ang_r[k-1] * $signed({1'b0, side_r[k-1].th});
      ang_nxt[k] = ANG_COEF[coefficient_set_r][3-k] + acc_t'(ang_pr[k] >>> 8);
    end
    ang_pr[4]  = ang_r[3] * $signed({1'b0, side_r[3].th});
    ang_nxt[4] = ANG_ONE + acc_t'(ang_pr[4] >>> 8);
    a_q24 = ang_r[4][47:12];
    f_pr  = a_q24 * ANG_SCALE[coefficient_set_r];
    f_nxt = f_t'(f_pr >>> 30);
  end

  gcp_log2 u_log2 (
    .clk     (clk),
    .e       (e_r),
    .log_q24 (log_q24)
  );

  // X = ln(E/me) in Q.16 and the three Horner chains
  always_comb begin
    d    = log_q24 - LOG2_ME_Q24;
    x_pr = 59'(d) * 59'(LN2_Q30);
    for (int i = 0; i < 3; i++) begin
      h_pr[i][0]     = XS_COEF[i][5] * $signed({1'b0, x_r[0]});
      hacc_nxt[i][0] = XS_COEF[i][4] + acc_t'(h_pr[i][0] >>> 16);
      for (int j = 1; j < 5; j++) begin
        h_pr[i][j]     = hacc_r[i][j-1] * $signed({1'b0, x_r[j]});
        hacc_nxt[i][j] = XS_COEF[i][4-j] + acc_t'(h_pr[i][j] >>> 16);
      end
    end
  end

  // cross section per atom and final product
  always_comb begin
    zs      = $signed({1'b0, atomic_number_r});
    z1      = $signed({2'b00, atomic_number_r}) + 9'sd1;
    p0_nxt  = hacc_r[0][4] * zs;
    p1_nxt  = hacc_r[1][4] * zs;
    q1_nxt  = p1_r * zs;
    t_nxt   = 64'(p0b_r) + q1_r + 64'(c2b_r);
    s_pr    = t_r * z1;
    s_sh    = s_r[63:16];
    if (s_sh > 48'sd68719476736)
      s24_nxt = S24_W'(48'sd68719476736);
    else if (s_sh < -48'sd68719476736)
      s24_nxt = S24_W'(-48'sd68719476736);
    else
      s24_nxt = S24_W'(s_sh);
    fin_pr = side_r[NSTG-1].f * s24_r;
    fin    = fin_pr[67:32];
    if (fin < 0)
      prob_c = '0;
    else if (fin > 36'sd16777215)
      prob_c = 24'hFFFFFF;
    else
      prob_c = fin[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 0; k < NSTG-1; k++) vld_r[k+1] <= vld_r[k];
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    e_r       <= e_nxt;
    for (int k = 0; k < NSTG-1; k++) begin
      if (k != 4) side_r[k+1] <= side_r[k];
    end
    side_r[5] <= '{path: side_r[4].path, val: side_r[4].val, th: side_r[4].th, f: f_nxt};
    for (int k = 1; k <= 4; k++) ang_r[k] <= ang_nxt[k];
    x_r[0] <= X_W'(x_pr >> 38);
    for (int j = 0; j < 4; j++) x_r[j+1] <= x_r[j];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 5; j++) hacc_r[i][j] <= hacc_nxt[i][j];
    end
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    c2_r  <= hacc_r[2][4];
    p0b_r <= p0_r;
    c2b_r <= c2_r;
    q1_r  <= q1_nxt;
    t_r   <= t_nxt;
    s_r   <= s_pr[63:0];
    s24_r <= s24_nxt;
    out_path_r        <= side_r[NSTG-1].path;
    out_probability_r <= (side_r[NSTG-1].path == PATH_COMPUTED) ? prob_c
                                                                : side_r[NSTG-1].val;
  end

  assign out_valid       = out_valid_r;
  assign out_probability = out_probability_r;
  assign out_path_taken  = out_path_r;

endmodule

// ===== dv/gamma_conversion_probability_tb.sv =====
// Self-checking testbench for gamma_conversion_probability.
// Depends on gcp_pkg and the block's RTL; a bit-exact fixed point predictor
// and a small scoreboard check every result against its photon transfer.
module gamma_conversion_probability_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcp_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct {
    logic [23:0] prob;
    path_t       path;
  } conv_result_t;

  function automatic longint qfix(longint n, longint d, int s);
    return (n * (64'sd1 <<< s) + d / 2) / d;
  endfunction

  class conv_scoreboard;
    conv_result_t pending[$];
    int           errors;
    logic [6:0]   z_reg;
    logic [16:0]  fixed_reg;
    logic [1:0]   set_reg;
    longint       xs[3][6];
    longint       kscale[4];
    longint       ang[4][4];

    function new();
      z_reg = 7'd41;
      fixed_reg = '0;
      set_reg = '0;
      xs[0] = '{qfix(87842, 100000000, 40), -qfix(19625, 10000000, 40),
                qfix(12949, 10000000, 40), -qfix(20028, 100000000, 40),
                qfix(12575, 1000000000, 40), -qfix(28333, 64'sd100000000000, 40)};
      xs[1] = '{-qfix(10342, 1000000000, 40), qfix(17692, 1000000000, 40),
                -qfix(82391, 64'sd10000000000, 40), qfix(13063, 64'sd10000000000, 40),
                -qfix(90815, 64'sd1000000000000, 40),
                qfix(23586, 64'sd10000000000000, 40)};
      xs[2] = '{-qfix(45263, 100000000, 40), qfix(11161, 10000000, 40),
                -qfix(86749, 100000000, 40), qfix(21773, 100000000, 40),
                -qfix(20467, 1000000000, 40), qfix(65372, 64'sd100000000000, 40)};
      kscale = '{qfix(4319, 1000000, 30), qfix(649, 100000, 30),
                 qfix(380904, 100000000, 30), qfix(4319, 1000000, 30)};
      ang[0] = '{-qfix(2322, 100000, 36), qfix(359, 1000000, 36), 0, 0};
      ang[1] = '{qfix(740, 100000, 36), qfix(397, 10000000, 36), 0, 0};
      ang[2] = '{-qfix(777771, 10000000, 36), qfix(522763, 100000000, 36),
                 -qfix(133942, 1000000000, 36), qfix(149021, 64'sd100000000000, 36)};
      ang[3] = ang[0];
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] data);
      case (idx)
        REG_ATOMIC: z_reg = data[6:0];
        REG_FIXED:  fixed_reg = data;
        REG_SET:    set_reg = data[1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned log2_q24(logic [23:0] e);
      int p;
      longint unsigned y, frac;
      p = 0;
      frac = 0;
      for (int i = 0; i < 24; i++) if (e[i]) p = i;
      y = longint'(e) << (30 - p);
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 30;
        frac = frac << 1;
        if (y >= (64'd1 << 31)) begin
          frac = frac | 1;
          y = y >> 1;
        end
      end
      return (longint'(p) << 24) | frac;
    endfunction

    function void note_photon(logic [23:0] energy, logic signed [16:0] angle);
      conv_result_t r;
      longint th, zz, acc, s, a, f, p, x;
      longint cc[3];
      longint unsigned d;
      logic [23:0] e;
      int cs;
      th = angle;
      e = energy;
      cs = set_reg;
      zz = z_reg;
      if (th < 0 || th > 23040) r = '{24'd0, PATH_ANGLE};
      else if (fixed_reg >= 17'd65536) r = '{24'd65536, PATH_ALL};
      else if (fixed_reg != 0) r = '{24'(fixed_reg), PATH_FIXED};
      else if (e < 24'd1022) r = '{24'd0, PATH_BELOW};
      else begin
        if (e > 24'd10000000) e = 24'd10000000;
        d = log2_q24(e) - longint'(qfix(899717683, 100000000, 24));
        x = longint'(((d * longint'(qfix(64'sd6931471806, 64'sd10000000000, 30))) >> 30)
                     >> 8);
        for (int i = 0; i < 3; i++) begin
          acc = xs[i][5];
          for (int j = 4; j >= 0; j--) acc = xs[i][j] + ((acc * x) >>> 16);
          cc[i] = acc;
        end
        s = (zz + 1) * (cc[0] * zz + cc[1] * zz * zz + cc[2]);
        s = s >>> 16;
        if (s > (64'sd1 <<< 36)) s = 64'sd1 <<< 36;
        if (s < -(64'sd1 <<< 36)) s = -(64'sd1 <<< 36);
        acc = ang[cs][3];
        for (int j = 2; j >= 0; j--) acc = ang[cs][j] + ((acc * th) >>> 8);
        acc = (64'sd1 <<< 36) + ((acc * th) >>> 8);
        a = acc >>> 12;
        f = (a * kscale[cs]) >>> 30;
        p = (f * s) >>> 32;
        if (p < 0) p = 0;
        if (p > 64'sd16777215) p = 64'sd16777215;
        r = '{p[23:0], PATH_COMPUTED};
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [23:0] prob, logic [2:0] path);
      conv_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: probability %0d path %0d", prob, path);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (prob !== r.prob) begin
        $error("probability: expected %0d, actual %0d", r.prob, prob);
        errors++;
      end
      if (path !== r.path) begin
        $error("path_taken: expected %0d, actual %0d", r.path, path);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_photon_energy = '0;
  logic signed [16:0] in_polar_angle = '0;
  logic out_valid;
  logic [23:0] out_probability;
  logic [2:0] out_path_taken;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  conv_scoreboard sb = new();
  bit no_gaps;

  gamma_conversion_probability i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_probability, out_path_taken);
  end

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = no_gaps ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_photon(logic [23:0] energy, logic signed [16:0] angle);
    idle_gap();
    start <= 1'b1;
    in_photon_energy <= energy;
    in_polar_angle <= angle;
    do @(posedge clk); while (busy);
    sb.note_photon(energy, angle);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_energy();
    int k;
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 1021));
      2: return 24'($urandom_range(10000000, 16777215));
      default: begin
        k = $urandom_range(0, 23);
        return 24'(1022 + ($urandom & ((1 << k) - 1)));
      end
    endcase
  endfunction

  function automatic logic signed [16:0] rand_angle();
    if ($urandom_range(0, 9) == 0) return 17'($urandom);
    return 17'($urandom_range(0, 23040));
  endfunction

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [23:0] de[8] = '{24'd0, 24'd1021, 24'd1022, 24'd1023, 24'd511000,
                           24'd10000000, 24'd10000001, 24'hFFFFFF};
    logic signed [16:0] da[7] = '{-17'sd65536, -17'sd46080, -17'sd1, 17'sd0,
                                  17'sd23040, 17'sd23041, 17'sd65535};
    int phase_z[10]   = '{41, 1, 100, 0, 127, 57, 57, 57, 57, 13};
    int phase_fix[10] = '{0, 0, 0, 0, 0, 1, 65535, 65536, 131071, 0};
    int phase_set[10] = '{0, 1, 2, 3, 2, 0, 1, 2, 0, 2};
    int count;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (de[i]) send_photon(de[i], 17'sd11520);
    foreach (da[i]) send_photon(24'd2000000, da[i]);
    for (int i = 0; i < 6; i++) send_photon(24'd1 << (i * 4 + 3), 17'(17'sd5000 * i));
    drain();
    write_reg(REG_NONE, 17'h1FFFF);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        write_reg(REG_ATOMIC, 17'($urandom) & ~17'h7F | 17'(phase_z[ph]));
        write_reg(REG_FIXED, 17'(phase_fix[ph]));
        write_reg(REG_SET, 17'(phase_set[ph]));
      end
      no_gaps = (ph % 3 == 1);
      count = (phase_fix[ph] != 0) ? 80 : 280;
      for (int i = 0; i < count; i++) begin
        send_photon(rand_energy(), rand_angle());
        if (ph == 2 && i == count / 2) drain();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== gamma_conversion_probability.f =====
rtl/gcp_pkg.sv
rtl/gcp_log2.sv
rtl/gamma_conversion_probability.sv
dv/gamma_conversion_probability_tb.sv
